// ===== hdl/mlqs_pkg.sv =====
// ----------------------------------------------------------------------------
// mlqs_pkg
// Shared types and constants of the multilevel queue scheduler.
// ----------------------------------------------------------------------------
package mlqs_pkg;

  // fixed field widths of the item, result and configuration ports
  localparam int TaskW  = 8;
  localparam int LevelW = 4;
  localparam int QuantW = 8;
  localparam int CfgW   = 8;

  // item operation codes
  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_TICK    = 1'b1
  } op_e;

  // configuration register indexes
  typedef enum logic {
    CFG_QUANTUM   = 1'b0,
    CFG_FCFS_LAST = 1'b1
  } cfg_idx_e;

  // input item
  typedef struct packed {
    logic              op;
    logic [TaskW-1:0]  task_id;
    logic [LevelW-1:0] task_level;
    logic              release_req;
  } item_t;

  // result item
  typedef struct packed {
    logic              running_valid;
    logic [TaskW-1:0]  running_task;
    logic [LevelW-1:0] running_level;
    logic              dispatched;
    logic              status;
  } result_t;

  // classified command handed from the front end to the scheduler
  typedef struct packed {
    logic              is_tick;
    logic [TaskW-1:0]  task_id;
    logic [LevelW-1:0] task_level;
    logic              level_ok;
    logic              release_req;
  } cmd_t;

  // scheduler sequencer states
  typedef enum logic [2:0] {
    ST_DECIDE = 3'b001,
    ST_SELECT = 3'b010,
    ST_LOAD   = 3'b100
  } state_e;

endpackage

// ===== hdl/mlqs_fifo.sv =====
// ----------------------------------------------------------------------------
// mlqs_fifo
// Small register FIFO with a full/empty handshake.
// ----------------------------------------------------------------------------
module mlqs_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_en_i,
  input  T     wr_data_i,
  output logic full_o,
  input  logic rd_en_i,
  output T     rd_data_o,
  output logic empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  T                slot_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_wr, do_rd;

  assign full_o    = (cnt_q == CntW'(DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = slot_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // payload slots
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slot_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ===== hdl/mlqs_front.sv =====
// ----------------------------------------------------------------------------
// mlqs_front
// Input side: classifies items and buffers them ahead of the scheduler.
// ----------------------------------------------------------------------------
module mlqs_front #(
  parameter int NUM_LEVELS = 10
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           full_o,
  input  mlqs_pkg::item_t item_i,
  output logic           cmd_valid_o,
  input  logic           cmd_pop_i,
  output mlqs_pkg::cmd_t cmd_o
);

  import mlqs_pkg::*;

  cmd_t cmd_in;
  logic cmd_empty;

  // decode the operation and check the level range
  always_comb begin
    cmd_in.is_tick     = (item_i.op == OP_TICK);
    cmd_in.task_id     = item_i.task_id;
    cmd_in.task_level  = item_i.task_level;
    cmd_in.level_ok    = (int'(item_i.task_level) < NUM_LEVELS);
    cmd_in.release_req = item_i.release_req;
  end

  // decoupling queue toward the scheduler
  mlqs_fifo #(
    .T     (cmd_t),
    .DEPTH (2)
  ) u_cmd_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (push_i),
    .wr_data_i (cmd_in),
    .full_o    (full_o),
    .rd_en_i   (cmd_pop_i),
    .rd_data_o (cmd_o),
    .empty_o   (cmd_empty)
  );

  assign cmd_valid_o = !cmd_empty;

endmodule

// ===== hdl/mlqs_back.sv =====
// ----------------------------------------------------------------------------
// mlqs_back
// Scheduler core: level queues, cpu slot, quantum and dispatch sequencer.
// ----------------------------------------------------------------------------
module mlqs_back #(
  parameter int NUM_LEVELS   = 10,
  parameter int QUEUE_DEPTH  = 16,
  parameter int TASK_ID_BITS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  output logic                        cmd_pop_o,
  input  mlqs_pkg::cmd_t              cmd_i,
  input  logic                        res_full_i,
  output logic                        res_valid_o,
  output mlqs_pkg::result_t           res_o,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [mlqs_pkg::CfgW-1:0]   cfg_wdata_i
);

  import mlqs_pkg::*;

  localparam int LvlW  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int HeadW = $clog2(QUEUE_DEPTH);
  localparam int CntW  = $clog2(QUEUE_DEPTH + 1);
  localparam int SumW  = $clog2(2 * QUEUE_DEPTH);
  localparam int MemN  = NUM_LEVELS * QUEUE_DEPTH;
  localparam int AddrW = $clog2(MemN);
  localparam int IdW   = (TASK_ID_BITS < TaskW) ? TASK_ID_BITS : TaskW;

  // task id store, one ring of QUEUE_DEPTH entries per level
  logic [IdW-1:0]    mem_q [MemN];
  logic [IdW-1:0]    rd_data_q;

  logic [HeadW-1:0]  head_q  [NUM_LEVELS];
  logic [CntW-1:0]   count_q [NUM_LEVELS];

  state_e            state_q, state_d;
  logic              cpu_busy_q, cpu_busy_d;
  logic [IdW-1:0]    cpu_task_q, cpu_task_d;
  logic [LvlW-1:0]   cpu_level_q, cpu_level_d;
  logic [QuantW-1:0] quantum_q, quantum_d;
  logic [QuantW-1:0] quantum_len_q;
  logic [LevelW-1:0] fcfs_last_q;
  logic [LvlW-1:0]   sel_q, sel_d;
  logic              release_q, release_d;

  logic              any_ready;
  logic [LvlW-1:0]   top;
  logic [LvlW-1:0]   cmd_lvl;
  logic [LvlW-1:0]   acc_lvl;
  logic [HeadW-1:0]  acc_head;
  logic [CntW-1:0]   acc_cnt;
  logic              acc_full;
  logic [SumW-1:0]   slot_sum;
  logic [HeadW-1:0]  tail_slot;
  logic [HeadW-1:0]  head_inc;
  logic [AddrW-1:0]  mem_addr;

  logic              go;
  logic              rr_level, expire, preempt, need_push;
  logic [QuantW-1:0] quantum_now, quantum_dec, quantum_len_dec;
  logic              mem_we, cnt_we, head_we;
  logic [CntW-1:0]   cnt_new;
  logic [TaskW-1:0]  cur_task;
  logic [LevelW-1:0] cur_level;

  // highest-priority (lowest-numbered) non-empty level
  always_comb begin
    any_ready = 1'b0;
    top       = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (count_q[i] != '0) begin
        any_ready = 1'b1;
        top       = LvlW'(i);
      end
    end
  end

  // single access port into the head and count tables
  assign cmd_lvl = cmd_i.task_level[LvlW-1:0];

  always_comb begin
    if (state_q == ST_SELECT) begin
      acc_lvl = top;
    end else if (cmd_i.is_tick) begin
      acc_lvl = cpu_level_q;
    end else if (cmd_i.level_ok) begin
      acc_lvl = cmd_lvl;
    end else begin
      acc_lvl = '0;
    end
  end

  assign acc_head  = head_q[acc_lvl];
  assign acc_cnt   = count_q[acc_lvl];
  assign acc_full  = (acc_cnt == CntW'(QUEUE_DEPTH));
  assign slot_sum  = SumW'(acc_head) + SumW'(acc_cnt);
  assign tail_slot = (slot_sum >= SumW'(QUEUE_DEPTH)) ?
                     HeadW'(slot_sum - SumW'(QUEUE_DEPTH)) : HeadW'(slot_sum);
  assign head_inc  = (acc_head == HeadW'(QUEUE_DEPTH - 1)) ? '0 : acc_head + 1'b1;
  assign mem_addr  = AddrW'(acc_lvl) * AddrW'(QUEUE_DEPTH) +
                     AddrW'((state_q == ST_SELECT) ? acc_head : tail_slot);

  // scheduling decision on a tick
  assign rr_level    = LevelW'(cpu_level_q) > fcfs_last_q;
  assign expire      = cpu_busy_q && rr_level && (quantum_q == '0);
  assign preempt     = cpu_busy_q && !expire && any_ready && (top < cpu_level_q);
  assign need_push   = (expire || preempt) && !acc_full;
  assign quantum_now = expire ? quantum_len_q : quantum_q;
  assign quantum_dec = (quantum_now != '0) ? quantum_now - 1'b1 : '0;
  assign quantum_len_dec = (quantum_len_q != '0) ? quantum_len_q - 1'b1 : '0;

  assign cur_task  = cpu_busy_q ? TaskW'(cpu_task_q) : '0;
  assign cur_level = cpu_busy_q ? LevelW'(cpu_level_q) : '0;

  assign go = cmd_valid_i && !res_full_i;

  // sequencer
  always_comb begin
    state_d     = state_q;
    cpu_busy_d  = cpu_busy_q;
    cpu_task_d  = cpu_task_q;
    cpu_level_d = cpu_level_q;
    quantum_d   = quantum_q;
    sel_d       = sel_q;
    release_d   = release_q;
    mem_we      = 1'b0;
    cnt_we      = 1'b0;
    head_we     = 1'b0;
    cnt_new     = acc_cnt;
    cmd_pop_o   = 1'b0;
    res_valid_o = 1'b0;
    res_o.running_valid = cpu_busy_q;
    res_o.running_task  = cur_task;
    res_o.running_level = cur_level;
    res_o.dispatched    = 1'b0;
    res_o.status        = 1'b0;

    unique case (state_q)
      ST_DECIDE: begin
        if (go) begin
          cmd_pop_o = 1'b1;
          release_d = cmd_i.release_req;
          if (!cmd_i.is_tick) begin
            // enqueue into the tail of its level
            if (cmd_i.level_ok && !acc_full) begin
              mem_we  = 1'b1;
              cnt_we  = 1'b1;
              cnt_new = acc_cnt + 1'b1;
            end else begin
              res_o.status = 1'b1;
            end
            res_valid_o = 1'b1;
          end else if ((!cpu_busy_q && any_ready) || need_push) begin
            // requeue the running task if needed, then dispatch
            if (need_push) begin
              mem_we  = 1'b1;
              cnt_we  = 1'b1;
              cnt_new = acc_cnt + 1'b1;
            end
            state_d = ST_SELECT;
          end else begin
            // task keeps the cpu or cpu stays idle
            res_valid_o = 1'b1;
            if (cpu_busy_q) begin
              quantum_d = quantum_dec;
              if (cmd_i.release_req) begin
                cpu_busy_d = 1'b0;
              end
            end
          end
        end
      end
      ST_SELECT: begin
        // pop the head of the highest non-empty level
        head_we = 1'b1;
        cnt_we  = 1'b1;
        cnt_new = acc_cnt - 1'b1;
        sel_d   = top;
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        // popped id arrives from the store
        cpu_task_d  = rd_data_q;
        cpu_level_d = sel_q;
        cpu_busy_d  = !release_q;
        quantum_d   = quantum_len_dec;
        res_valid_o = 1'b1;
        res_o.running_valid = 1'b1;
        res_o.running_task  = TaskW'(rd_data_q);
        res_o.running_level = LevelW'(sel_q);
        res_o.dispatched    = 1'b1;
        state_d = ST_DECIDE;
      end
      default: begin
        state_d = ST_DECIDE;
      end
    endcase
  end

  // control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_DECIDE;
      cpu_busy_q    <= 1'b0;
      cpu_task_q    <= '0;
      cpu_level_q   <= '0;
      quantum_q     <= '0;
      quantum_len_q <= QuantW'(10);
      fcfs_last_q   <= LevelW'(4);
      sel_q         <= '0;
      release_q     <= 1'b0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_q[i]  <= '0;
        count_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      cpu_busy_q  <= cpu_busy_d;
      cpu_task_q  <= cpu_task_d;
      cpu_level_q <= cpu_level_d;
      quantum_q   <= quantum_d;
      sel_q       <= sel_d;
      release_q   <= release_d;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        if (cnt_we && (acc_lvl == LvlW'(i))) begin
          count_q[i] <= cnt_new;
        end
        if (head_we && (acc_lvl == LvlW'(i))) begin
          head_q[i] <= head_inc;
        end
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_QUANTUM:   quantum_len_q <= cfg_wdata_i[QuantW-1:0];
          CFG_FCFS_LAST: fcfs_last_q   <= cfg_wdata_i[LevelW-1:0];
          default:       quantum_len_q <= quantum_len_q;
        endcase
      end
    end
  end

  // task id store: one write or one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= IdW'(cmd_i.is_tick ? TaskW'(cpu_task_q) : cmd_i.task_id);
    end
    if (state_q == ST_SELECT) begin
      rd_data_q <= mem_q[mem_addr];
    end
  end

endmodule

// ===== hdl/multilevel_queue_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// multilevel_queue_scheduler_core
// Multilevel queue scheduler with FCFS upper levels and round robin below.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter through push/full: an item is taken when push is high and
//   full is low. An item either enqueues a task on a level or is one tick.
//   Every item produces exactly one result, read through empty/pop in order.
//   Configuration (quantum length, FCFS boundary) is written through
//   cfg_we_i/cfg_idx_i/cfg_wdata_i while the block is idle.
// Timing:
//   The scheduler takes an item out of the two-entry input queue while it
//   is in the decide state and the output queue has room. An enqueue or a
//   tick that keeps the cpu is finished in decide; a tick that dispatches
//   passes through decide, store read and load, and its result is written
//   in load. Throughput is one item per cycle while the output queue has
//   room; no item is taken during a dispatch, which waits for the store read.
// Reset:
//   All level queues empty, cpu idle, quantum 10, FCFS boundary level 4.
//   The task id store is not cleared; only counted entries are ever read.
// Stalls:
//   A result waits in a two-entry output queue; the scheduler stops taking
//   new items while that queue is full, and full rises once input fills.
// ----------------------------------------------------------------------------
module multilevel_queue_scheduler_core #(
  parameter int NUM_LEVELS   = 10,
  parameter int QUEUE_DEPTH  = 16,
  parameter int TASK_ID_BITS = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  mlqs_pkg::item_t           item_i,
  output logic                      empty,
  input  logic                      pop,
  output mlqs_pkg::result_t         result_o,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [mlqs_pkg::CfgW-1:0] cfg_wdata_i
);

  import mlqs_pkg::*;

  cmd_t    cmd;
  logic    cmd_valid, cmd_pop;
  result_t res;
  logic    res_valid, res_full;

  // front end: classify and buffer
  mlqs_front #(
    .NUM_LEVELS (NUM_LEVELS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .item_i      (item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd)
  );

  // back end: scheduler
  mlqs_back #(
    .NUM_LEVELS   (NUM_LEVELS),
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .TASK_ID_BITS (TASK_ID_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .cmd_i       (cmd),
    .res_full_i  (res_full),
    .res_valid_o (res_valid),
    .res_o       (res),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // result queue toward the consumer
  mlqs_fifo #(
    .T     (result_t),
    .DEPTH (2)
  ) u_res_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (res_valid),
    .wr_data_i (res),
    .full_o    (res_full),
    .rd_en_i   (pop),
    .rd_data_o (result_o),
    .empty_o   (empty)
  );

endmodule

// ===== hdl/mlqs_checker.sv =====
// ----------------------------------------------------------------------------
// mlqs_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module mlqs_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              push,
  input logic              full,
  input mlqs_pkg::item_t   item_i,
  input logic              empty,
  input logic              pop,
  input mlqs_pkg::result_t result_o
);

  import mlqs_pkg::*;

  // a new dispatch always shows a running task
  a_dispatch_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.dispatched) |-> result_o.running_valid)
    else $error("dispatched result without running task");

  // a dropped enqueue never reports a dispatch
  a_drop_no_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.status) |-> !result_o.dispatched)
    else $error("dropped enqueue flagged as dispatch");

  // idle cpu reports zero task and level
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !result_o.running_valid) |->
      (result_o.running_task == '0) && (result_o.running_level == '0))
    else $error("idle result carries task or level");

  // a waiting result holds until taken
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(result_o)))
    else $error("waiting result changed");

endmodule

bind multilevel_queue_scheduler_core mlqs_checker u_mlqs_checker (.*);
